// File: rtl/windowed_channel_sum_argmax_macros.svh
// Assertion macros used by the checker file of the windowed channel sum block.
`ifndef WINDOWED_CHANNEL_SUM_ARGMAX_MACROS_SVH
`define WINDOWED_CHANNEL_SUM_ARGMAX_MACROS_SVH

// Property checked at every rising edge, reset included.
`define WCSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Property checked only while out of reset.
`define WCSA_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// File: rtl/wcsa_pkg.sv
// Types and constants of the windowed channel sum and selection block.
package wcsa_pkg;

  localparam int CH_W   = 5;
  localparam int SMP_W  = 16;
  localparam int SUM_W  = 36;
  localparam int WIN_W  = 19;
  localparam int CFG_IDX_W = 1;

  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [SMP_W-1:0] smp_t;
  typedef logic        [WIN_W-1:0] win_t;
  typedef logic        [CH_W-1:0]  ch_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_STEPS     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SELECT_THRESHOLD = 1'b1;

  // Register reset values.
  localparam win_t WINDOW_STEPS_RST     = WIN_W'(400000);
  localparam sum_t SELECT_THRESHOLD_RST = SUM_W'(64'sd3932160000);

  // Saturation limits of a channel sum.
  localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

endpackage

// File: rtl/windowed_channel_sum_argmax.sv
// Top level of the windowed per-channel sum with threshold argmax selection.
//
// Input channel (in_*): one request carries one channel sample; in_tlast marks
// the last channel of a time step. Each channel's sum is kept over window_steps
// time steps. During the final step of a window every updated sum is compared
// with select_threshold and with the best sum so far; the earlier channel wins
// a tie. When the final step ends, one result request on out_* gives the
// winning channel plus one, or zero when no channel qualified, and all sums
// are cleared.
// Throughput is one request per cycle outside the stall below: the sum
// registers are read, added, saturated and compared combinationally between
// the input register and the sum and result registers, so equal channels back
// to back need no bypass. A result passes the input register, then the result
// register. When the receiver stalls, input is still taken until a step-ending
// request of a final step reaches the input register; that one waits for the
// output register to drain. Reset clears all sums, the step count and the best
// channel and loads the configuration reset values. Configuration writes
// (cfg_*) take effect at once; the user makes them while idle, not enforced.
module windowed_channel_sum_argmax
  import wcsa_pkg::*;
#(
  parameter int CHANNELS = 19
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Input requests.
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [23:0]          in_tdata,   // [4:0] channel, [20:5] sample, [23:21] zero
  input  logic                 in_tlast,   // end_of_step
  // Result requests.
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // [4:0] selected, [7:5] zero
  // Configuration writes.
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SUM_W-1:0]     cfg_wdata
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Configuration registers.
  win_t window_steps_r;
  sum_t threshold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_steps_r <= WINDOW_STEPS_RST;
      threshold_r    <= SELECT_THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_STEPS:     window_steps_r <= cfg_wdata[WIN_W-1:0];
        CFG_SELECT_THRESHOLD: threshold_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register stage.
  logic stage_v_r;
  ch_t  ch_r;
  smp_t smp_r;
  logic eos_r;

  logic stage_go;
  logic in_acc;

  assign in_acc = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else if (in_acc) begin
      stage_v_r <= 1'b1;
    end else if (stage_go) begin
      stage_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ch_r  <= in_tdata[CH_W-1:0];
      smp_r <= in_tdata[CH_W+SMP_W-1:CH_W];
      eos_r <= in_tlast;
    end
  end

  // Window state.
  sum_t       sums_r [CHANNELS];
  win_t       step_cnt_r;
  sum_t       best_sum_r;
  ch_t        best_ch_r;

  // Final step decision: the window value zero behaves as one.
  logic [WIN_W:0] win_eff;
  logic [WIN_W:0] step_next;
  logic           final_step;

  assign win_eff    = (window_steps_r == '0) ? (WIN_W+1)'(1) : {1'b0, window_steps_r};
  assign step_next  = {1'b0, step_cnt_r} + (WIN_W+1)'(1);
  assign final_step = step_next >= win_eff;

  // Accumulate with saturation and compare against threshold and best.
  logic             in_range;
  logic [IDX_W-1:0] idx;
  sum_t             cur_sum;
  logic signed [SUM_W:0] wide_sum;
  sum_t             new_sum;
  logic             take_best;
  logic             emit;
  logic             out_free;

  assign in_range = ch_r < CH_W'(CHANNELS);
  assign idx      = ch_r[IDX_W-1:0];
  assign cur_sum  = in_range ? sums_r[idx] : '0;
  assign wide_sum = {cur_sum[SUM_W-1], cur_sum} + (SUM_W+1)'(smp_r);

  always_comb begin
    if (wide_sum[SUM_W] != wide_sum[SUM_W-1]) begin
      new_sum = wide_sum[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      new_sum = wide_sum[SUM_W-1:0];
    end
  end

  assign take_best = in_range && final_step && (new_sum > threshold_r)
                     && (new_sum > best_sum_r);
  assign emit      = eos_r && final_step;
  assign out_free  = !out_tvalid || out_tready;
  assign stage_go  = stage_v_r && (!emit || out_free);
  assign in_tready = !stage_v_r || stage_go;

  // Sum registers: updated per request, cleared when a window closes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        sums_r[i] <= '0;
      end
    end else if (stage_go) begin
      if (emit) begin
        for (int i = 0; i < CHANNELS; i++) begin
          sums_r[i] <= '0;
        end
      end else if (in_range) begin
        sums_r[idx] <= new_sum;
      end
    end
  end

  // Step count and best-so-far tracking.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_cnt_r <= '0;
      best_sum_r <= '0;
      best_ch_r  <= '0;
    end else if (stage_go) begin
      if (emit) begin
        step_cnt_r <= '0;
        best_sum_r <= '0;
        best_ch_r  <= '0;
      end else begin
        if (eos_r) begin
          step_cnt_r <= step_next[WIN_W-1:0];
        end
        if (take_best) begin
          best_sum_r <= new_sum;
          best_ch_r  <= ch_r + CH_W'(1);
        end
      end
    end
  end

  // Result register.
  logic out_v_r;
  ch_t  sel_r;
  ch_t  sel_nxt;

  assign sel_nxt = take_best ? ch_r + CH_W'(1) : best_ch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (stage_go && emit) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_go && emit) begin
      sel_r <= sel_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {3'b000, sel_r};

endmodule

// File: rtl/wcsa_checker.sv
// Port-level checker for the windowed channel sum block, with its bind.
`include "windowed_channel_sum_argmax_macros.svh"

module wcsa_checker
  import wcsa_pkg::*;
#(
  parameter int CHANNELS = 19
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tvalid,
  input logic                 in_tready,
  input logic [23:0]          in_tdata,
  input logic                 in_tlast,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [7:0]           out_tdata,
  input logic                 cfg_we,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [SUM_W-1:0]     cfg_wdata
);

  // No result is offered in the cycle after reset.
  `WCSA_ASSERT(a_no_result_after_reset, !rst_n |=> !out_tvalid, "result offered after reset")

  // A stalled result request holds its data.
  `WCSA_ASSERT_RUN(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")

  // Input only stalls behind a waiting result.
  `WCSA_ASSERT_RUN(a_stall_cause, !in_tready |-> out_tvalid, "input stalled with empty output")

  // The selection is zero or a valid channel plus one, with zero padding.
  `WCSA_ASSERT_RUN(a_sel_range, out_tvalid |-> (out_tdata[4:0] <= CH_W'(CHANNELS)) && (out_tdata[7:5] == 3'b000), "selection out of range")

endmodule

bind windowed_channel_sum_argmax wcsa_checker #(.CHANNELS(CHANNELS)) u_wcsa_checker (.*);

// File: tb/tb_windowed_channel_sum_argmax.sv
// Self-checking testbench for the windowed channel sum and threshold selection block.
module tb_windowed_channel_sum_argmax;
  import wcsa_pkg::*;

  localparam int N_CHANNELS  = 19;
  localparam int CYCLE_LIMIT = 400000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [23:0]          in_tdata = '0;   // [4:0] channel, [20:5] sample, [23:21] zero
  logic                 in_tlast = 1'b0; // end_of_step
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;       // [4:0] selected, [7:5] zero
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_WINDOW_STEPS;
  logic [SUM_W-1:0]     cfg_wdata = '0;

  // Idle rates in percent for the sending and receiving sides.
  int unsigned send_idle_pct = 8;
  int unsigned recv_idle_pct = 58;

  int error_count = 0;
  int samples_sent = 0;
  int selections_predicted = 0;
  int selections_checked = 0;
  int cycle_count = 0;

  // Predicted state of the block.
  sum_t chan_sums [N_CHANNELS];
  win_t window_len;
  win_t steps_done;
  sum_t threshold;
  sum_t best_sum;
  ch_t  best_choice;
  ch_t  selection_queue [$];
  ch_t  wanted;

  windowed_channel_sum_argmax #(.CHANNELS(N_CHANNELS)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver readiness, redrawn every cycle.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each result request with the oldest predicted selection.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (selection_queue.size() == 0) begin
        $error("selected: no result expected, actual %0d", out_tdata[CH_W-1:0]);
        error_count++;
      end else begin
        wanted = selection_queue.pop_front();
        if (out_tdata[CH_W-1:0] !== wanted) begin
          $error("selected: expected %0d, actual %0d", wanted, out_tdata[CH_W-1:0]);
          error_count++;
        end
        selections_checked++;
      end
    end
  end

  // Forget all sums and the running best at the end of a window.
  function automatic void clear_window();
    foreach (chan_sums[i]) chan_sums[i] = '0;
    steps_done  = '0;
    best_sum    = '0;
    best_choice = '0;
  endfunction

  // Accumulate one accepted sample and queue a selection when a window closes.
  function automatic void predict_sample(ch_t ch, smp_t smp, logic eos);
    logic [WIN_W:0]          span;
    logic signed [SUM_W+1:0] total;
    sum_t                    upd;
    logic                    last_step;
    span = (window_len == '0) ? (WIN_W+1)'(1) : {1'b0, window_len};
    last_step = ({1'b0, steps_done} + (WIN_W+1)'(1)) >= span;
    if (ch < N_CHANNELS) begin
      total = (SUM_W+2)'(chan_sums[ch]) + (SUM_W+2)'(smp);
      if (total > SUM_MAX) upd = SUM_MAX;
      else if (total < SUM_MIN) upd = SUM_MIN;
      else upd = total[SUM_W-1:0];
      chan_sums[ch] = upd;
      // Strictly greater than both the threshold and the best so far, so ties keep the earlier channel.
      if (last_step && upd > threshold && upd > best_sum) begin
        best_sum    = upd;
        best_choice = ch + 1'b1;
      end
    end
    if (eos) begin
      if (last_step) begin
        selection_queue.push_back(best_choice);
        selections_predicted++;
        clear_window();
      end else begin
        steps_done = steps_done + 1'b1;
      end
    end
  endfunction

  // Offer one sample request, with a random gap first, and predict it on acceptance.
  task automatic send_sample(ch_t ch, smp_t smp, logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, smp, ch};
    in_tlast  <= eos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_sample(ch, smp, eos);
    samples_sent++;
  endtask

  // Stop sending and let every outstanding selection arrive.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (selection_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both registers while the block is idle.
  task automatic configure(win_t win, sum_t thr);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WINDOW_STEPS;
    cfg_wdata <= SUM_W'(win);
    @(posedge clk);
    cfg_index <= CFG_SELECT_THRESHOLD;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_we <= 1'b0;
    window_len = win;
    threshold  = thr;
  endtask

  function automatic smp_t random_sample();
    case ($urandom_range(9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2, 3:    return smp_t'($urandom_range(4000));
      default: return smp_t'($urandom);
    endcase
  endfunction

  // One time step: mostly channels in order ending with the step flag, sometimes noise.
  task automatic send_step();
    int  n;
    int  i;
    ch_t ch;
    n = ($urandom_range(1) == 0) ? N_CHANNELS : $urandom_range(N_CHANNELS, 1);
    if ($urandom_range(99) < 85) begin
      for (i = 0; i < n; i++) begin
        ch = ch_t'(i);
        if (i > 0 && $urandom_range(9) == 0) ch = ch_t'(i - 1);
        send_sample(ch, random_sample(), i == n - 1);
      end
    end else begin
      for (i = 0; i < n; i++)
        send_sample(ch_t'($urandom_range(31)), random_sample(), $urandom_range(3) == 0);
    end
  endtask

  // The reset window counts steps; shortening it makes the next step final.
  task automatic test_reset_window();
    send_sample(5'd0, 16'sd1000, 1'b0);
    send_sample(5'd5, -16'sd7, 1'b1);
    send_sample(5'd0, 16'sd2000, 1'b1);
    configure(win_t'(1), sum_t'(0));
    send_sample(5'd5, 16'sh7FFF, 1'b1);
  endtask

  // Window of zero, negative threshold, ties, repeats and out-of-range channels.
  task automatic test_single_step_cases();
    configure('0, SUM_MIN);
    send_sample(5'd0, 16'sh8000, 1'b0);
    send_sample(5'd18, -16'sd1, 1'b1);
    send_sample(5'd3, 16'sd100, 1'b0);
    send_sample(5'd7, 16'sd100, 1'b0);
    send_sample(5'd25, 16'sh7FFF, 1'b0);
    send_sample(5'd31, 16'sh7FFF, 1'b1);
    send_sample(5'd2, 16'sh7FFF, 1'b0);
    send_sample(5'd9, 16'sd20000, 1'b0);
    send_sample(5'd2, 16'sh8000, 1'b0);
    send_sample(5'd9, 16'sd20000, 1'b1);
  endtask

  // Highest threshold selects nothing; the longest window is cut short later.
  task automatic test_threshold_extremes();
    configure(win_t'(1), SUM_MAX);
    send_sample(5'd1, 16'sh7FFF, 1'b1);
    configure({WIN_W{1'b1}}, sum_t'(0));
    send_sample(5'd4, 16'sd500, 1'b1);
    send_sample(5'd4, 16'sd500, 1'b1);
    configure(win_t'(1), sum_t'(100));
    send_sample(5'd4, 16'sd1, 1'b1);
  endtask

  // Random windows and thresholds under each idling pattern.
  task automatic test_random_traffic();
    int   mode;
    int   first_sample;
    int   first_selection;
    int   setting_start;
    win_t win;
    sum_t thr;
    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0:       begin send_idle_pct = 8;  recv_idle_pct = 58; end
        1:       begin send_idle_pct = 58; recv_idle_pct = 8;  end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      first_sample    = samples_sent;
      first_selection = selections_predicted;
      while (samples_sent - first_sample < 400 ||
             selections_predicted - first_selection < 14) begin
        case ($urandom_range(5))
          0:       win = '0;
          1:       win = win_t'(1);
          default: win = win_t'($urandom_range(6, 2));
        endcase
        case ($urandom_range(4))
          0: thr = SUM_MIN;
          1: thr = '0;
          default: begin
            thr = sum_t'($urandom_range(200000));
            thr = thr - sum_t'(100000);
          end
        endcase
        configure(win, thr);
        setting_start = samples_sent;
        while (samples_sent - setting_start < 80) send_step();
      end
    end
  endtask

  initial begin
    window_len = WINDOW_STEPS_RST;
    threshold  = SELECT_THRESHOLD_RST;
    clear_window();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_window();
    test_single_step_cases();
    test_threshold_extremes();
    test_random_traffic();
    drain();

    $display("Sent %0d sample requests and checked %0d window selections.",
             samples_sent, selections_checked);
    $display("Covered window lengths 0 to maximum, threshold extremes and three idle patterns.");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
